FILE: rtl/assert_macros.svh
// Shared assertion macros for the triangle coverage RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a clock, with no reset qualification.
`define ASSERT_ALWAYS(label, clock, prop, msg) \
  label: assert property (@(posedge clock) prop) else $error(msg);

// Concurrent check on a clock, switched off while reset is high.
`define ASSERT_IF(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

FILE: rtl/tcc_pkg.sv
package tcc_pkg;

  // Width of the cell column and row inputs.
  localparam int CELL_BITS = 10;

  // Configuration register indexes.
  localparam int REG_IDX_BITS = 3;
  localparam logic [REG_IDX_BITS-1:0] REG_A_X  = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_A_Y  = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_B_X  = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_B_Y  = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_C_X  = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_C_Y  = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_HALF = 3'd6;

  // Vertex values after reset.
  localparam int RST_A_X = 50;
  localparam int RST_A_Y = 5;
  localparam int RST_B_X = 5;
  localparam int RST_B_Y = 80;
  localparam int RST_C_X = 100;
  localparam int RST_C_Y = 50;

  // Glyph codes on the result.
  typedef enum logic [1:0] {
    GLYPH_NONE = 2'd0,
    GLYPH_HALF = 2'd1,
    GLYPH_FULL = 2'd2
  } glyph_t;

  // Coverage found by the two sample lanes for one cell.
  typedef struct packed {
    logic top;
    logic bottom;
  } cover_t;

endpackage

FILE: rtl/tcc_setup.sv
// Shared edge unit: triangle edge vectors and the signed area term k,
// recomputed from the vertex registers every cycle.
module tcc_setup #(
  parameter int COORD_BITS = 12
) (
  input  logic                          clk,
  input  logic signed [COORD_BITS-1:0]  va_x,
  input  logic signed [COORD_BITS-1:0]  va_y,
  input  logic signed [COORD_BITS-1:0]  vb_x,
  input  logic signed [COORD_BITS-1:0]  vb_y,
  input  logic signed [COORD_BITS-1:0]  vc_x,
  input  logic signed [COORD_BITS-1:0]  vc_y,
  output logic signed [COORD_BITS:0]    e0x,
  output logic signed [COORD_BITS:0]    e0y,
  output logic signed [COORD_BITS:0]    e1x,
  output logic signed [COORD_BITS:0]    e1y,
  output logic signed [2*((COORD_BITS > tcc_pkg::CELL_BITS + 2 ?
                          COORD_BITS : tcc_pkg::CELL_BITS + 2) + 1):0] k
);

  localparam int ED = COORD_BITS + 1;
  localparam int DW = (COORD_BITS > tcc_pkg::CELL_BITS + 2 ?
                       COORD_BITS : tcc_pkg::CELL_BITS + 2) + 1;
  localparam int SW = 2 * DW + 1;

  logic signed [2*ED-1:0] kp0;
  logic signed [2*ED-1:0] kp1;

  // Edge vectors from the first vertex.
  always_ff @(posedge clk) begin
    e0x <= ED'(vc_x) - ED'(va_x);
    e0y <= ED'(vc_y) - ED'(va_y);
    e1x <= ED'(vb_x) - ED'(va_x);
    e1y <= ED'(vb_y) - ED'(va_y);
  end

  // Cross product terms, then their difference.
  always_ff @(posedge clk) begin
    kp0 <= e0x * e1y;
    kp1 <= e0y * e1x;
    k   <= SW'(kp0) - SW'(kp1);
  end

endmodule

FILE: rtl/tcc_lane.sv
`include "assert_macros.svh"

// One sample lane: barycentric test of a point against the triangle.
// Four register stages: offset, products, cross terms, compare.
module tcc_lane #(
  parameter int COORD_BITS = 12
) (
  input  logic                                clk,
  input  logic signed [COORD_BITS-1:0]        va_x,
  input  logic signed [COORD_BITS-1:0]        va_y,
  input  logic signed [COORD_BITS:0]          e0x,
  input  logic signed [COORD_BITS:0]          e0y,
  input  logic signed [COORD_BITS:0]          e1x,
  input  logic signed [COORD_BITS:0]          e1y,
  input  logic signed [2*((COORD_BITS > tcc_pkg::CELL_BITS + 2 ?
                          COORD_BITS : tcc_pkg::CELL_BITS + 2) + 1):0] k,
  input  logic        [tcc_pkg::CELL_BITS-1:0] px,
  input  logic        [tcc_pkg::CELL_BITS:0]   py,
  output logic                                hit
);

  localparam int DW = (COORD_BITS > tcc_pkg::CELL_BITS + 2 ?
                       COORD_BITS : tcc_pkg::CELL_BITS + 2) + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  logic signed [DW-1:0] wx;
  logic signed [DW-1:0] wy;
  logic signed [DW-1:0] e0x_w;
  logic signed [DW-1:0] e0y_w;
  logic signed [DW-1:0] e1x_w;
  logic signed [DW-1:0] e1y_w;
  logic signed [PW-1:0] pu0;
  logic signed [PW-1:0] pu1;
  logic signed [PW-1:0] pv0;
  logic signed [PW-1:0] pv1;
  logic signed [SW-1:0] su;
  logic signed [SW-1:0] sv;
  logic signed [SW:0]   sum;
  logic signed [SW:0]   kx;
  logic                 k_zero;
  logic                 hit_pos;
  logic                 hit_neg;

  assign e0x_w = DW'(e0x);
  assign e0y_w = DW'(e0y);
  assign e1x_w = DW'(e1x);
  assign e1y_w = DW'(e1y);

  // Sample point relative to the first vertex.
  always_ff @(posedge clk) begin
    wx <= $signed(DW'({1'b0, px})) - DW'(va_x);
    wy <= $signed(DW'(py)) - DW'(va_y);
  end

  // The four products of the two cross terms.
  always_ff @(posedge clk) begin
    pu0 <= wx * e1y_w;
    pu1 <= wy * e1x_w;
    pv0 <= e0x_w * wy;
    pv1 <= e0y_w * wx;
  end

  // Cross terms su = w x e1 and sv = e0 x w.
  always_ff @(posedge clk) begin
    su <= SW'(pu0) - SW'(pu1);
    sv <= SW'(pv0) - SW'(pv1);
  end

  // For negative k every inequality flips, so no negation is needed.
  assign sum     = (SW+1)'(su) + (SW+1)'(sv);
  assign kx      = (SW+1)'(k);
  assign k_zero  = (k == '0);
  assign hit_pos = !su[SW-1] && !sv[SW-1] && (sum < kx);
  assign hit_neg = (su[SW-1] || su == '0) && (sv[SW-1] || sv == '0) && (sum > kx);

  always_ff @(posedge clk) begin
    hit <= !k_zero && (k[SW-1] ? hit_neg : hit_pos);
  end

  // A degenerate triangle covers no sample.
  `ASSERT_ALWAYS(a_degenerate_outside, clk, (k == '0) |=> !hit, "sample inside a degenerate triangle")

endmodule

FILE: rtl/tcc_merge.sv
`include "assert_macros.svh"

// Merge stage: combines the two lane flags into the result beat.
module tcc_merge (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid,
  input  tcc_pkg::cover_t hits,
  input  logic            half_mode,
  output logic            done,
  output logic            top_inside,
  output logic            bottom_inside,
  output logic [1:0]      glyph
);

  tcc_pkg::glyph_t glyph_next;
  logic            bottom_next;

  assign bottom_next = half_mode && hits.bottom;

  // Half mode draws an upper half block; otherwise a full block.
  always_comb begin
    if (half_mode) begin
      glyph_next = (hits.top || hits.bottom) ? tcc_pkg::GLYPH_HALF : tcc_pkg::GLYPH_NONE;
    end else begin
      glyph_next = hits.top ? tcc_pkg::GLYPH_FULL : tcc_pkg::GLYPH_NONE;
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    top_inside    <= hits.top;
    bottom_inside <= bottom_next;
    glyph         <= glyph_next;
  end

  `ASSERT_IF(a_glyph_matches_cover, clk, rst, done |-> ((glyph != tcc_pkg::GLYPH_NONE) == (top_inside || bottom_inside)), "glyph disagrees with coverage flags")
  `ASSERT_IF(a_full_only_top, clk, rst, (done && glyph == tcc_pkg::GLYPH_FULL) |-> (top_inside && !bottom_inside), "full block with bottom sample")

endmodule

FILE: rtl/triangle_cell_coverage.sv
// Triangle cell coverage. A start beat carrying cell_column and cell_row is taken on
// any cycle in which busy is low; busy is high only while rst is held. One cell can
// be started every cycle, and its result appears as a single-cycle done beat with
// top_inside, bottom_inside and glyph. The receiver cannot stall the results, so
// done must be captured when it is high. The result is registered in the two sample
// lanes in parallel (offset, multiply, cross terms, compare), then the merge register.
// Vertex and half_mode writes must be made while no cell is in flight, and a cell
// should start no earlier than the cycle after the last write.
`include "assert_macros.svh"

module triangle_cell_coverage #(
  parameter int COORD_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [tcc_pkg::CELL_BITS-1:0]     cell_column,
  input  logic [tcc_pkg::CELL_BITS-1:0]     cell_row,
  input  logic                              wr_en,
  input  logic [tcc_pkg::REG_IDX_BITS-1:0]  wr_index,
  input  logic [COORD_BITS-1:0]             wr_data,
  output logic                              done,
  output logic                              top_inside,
  output logic                              bottom_inside,
  output logic [1:0]                        glyph
);

  localparam int ED = COORD_BITS + 1;
  localparam int DW = (COORD_BITS > tcc_pkg::CELL_BITS + 2 ?
                       COORD_BITS : tcc_pkg::CELL_BITS + 2) + 1;
  localparam int SW = 2 * DW + 1;
  localparam int LANE_LAT = 4;

  logic signed [COORD_BITS-1:0] va_x;
  logic signed [COORD_BITS-1:0] va_y;
  logic signed [COORD_BITS-1:0] vb_x;
  logic signed [COORD_BITS-1:0] vb_y;
  logic signed [COORD_BITS-1:0] vc_x;
  logic signed [COORD_BITS-1:0] vc_y;
  logic                         half_mode;
  logic signed [ED-1:0]         e0x;
  logic signed [ED-1:0]         e0y;
  logic signed [ED-1:0]         e1x;
  logic signed [ED-1:0]         e1y;
  logic signed [SW-1:0]         k;
  logic [LANE_LAT-1:0]          vld;
  tcc_pkg::cover_t              hits;

  assign busy = rst;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      va_x      <= COORD_BITS'(tcc_pkg::RST_A_X);
      va_y      <= COORD_BITS'(tcc_pkg::RST_A_Y);
      vb_x      <= COORD_BITS'(tcc_pkg::RST_B_X);
      vb_y      <= COORD_BITS'(tcc_pkg::RST_B_Y);
      vc_x      <= COORD_BITS'(tcc_pkg::RST_C_X);
      vc_y      <= COORD_BITS'(tcc_pkg::RST_C_Y);
      half_mode <= 1'b1;
    end else if (wr_en) begin
      unique case (wr_index)
        tcc_pkg::REG_A_X:  va_x      <= wr_data;
        tcc_pkg::REG_A_Y:  va_y      <= wr_data;
        tcc_pkg::REG_B_X:  vb_x      <= wr_data;
        tcc_pkg::REG_B_Y:  vb_y      <= wr_data;
        tcc_pkg::REG_C_X:  vc_x      <= wr_data;
        tcc_pkg::REG_C_Y:  vc_y      <= wr_data;
        tcc_pkg::REG_HALF: half_mode <= wr_data[0];
        default: ;
      endcase
    end
  end

  // Valid bits that travel alongside the lanes.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LANE_LAT-2:0], start && !busy};
    end
  end

  tcc_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .clk  (clk),
    .va_x (va_x),
    .va_y (va_y),
    .vb_x (vb_x),
    .vb_y (vb_y),
    .vc_x (vc_x),
    .vc_y (vc_y),
    .e0x  (e0x),
    .e0y  (e0y),
    .e1x  (e1x),
    .e1y  (e1y),
    .k    (k)
  );

  // Top sample lane at (col, 2*row).
  tcc_lane #(.COORD_BITS(COORD_BITS)) u_lane_top (
    .clk    (clk),
    .va_x   (va_x),
    .va_y   (va_y),
    .e0x    (e0x),
    .e0y    (e0y),
    .e1x    (e1x),
    .e1y    (e1y),
    .k      (k),
    .px     (cell_column),
    .py     ({cell_row, 1'b0}),
    .hit    (hits.top)
  );

  // Bottom sample lane at (col, 2*row+1).
  tcc_lane #(.COORD_BITS(COORD_BITS)) u_lane_bot (
    .clk    (clk),
    .va_x   (va_x),
    .va_y   (va_y),
    .e0x    (e0x),
    .e0y    (e0y),
    .e1x    (e1x),
    .e1y    (e1y),
    .k      (k),
    .px     (cell_column),
    .py     ({cell_row, 1'b1}),
    .hit    (hits.bottom)
  );

  tcc_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .valid         (vld[LANE_LAT-1]),
    .hits          (hits),
    .half_mode     (half_mode),
    .done          (done),
    .top_inside    (top_inside),
    .bottom_inside (bottom_inside),
    .glyph         (glyph)
  );

  // Every result beat answers a start beat that was taken earlier.
  `ASSERT_IF(a_done_has_start, clk, rst, done |-> $past(start && !busy, 5), "result beat without a start beat")

endmodule
